>>> hw/rtl/lrpd_pkg.sv
// Shared types and character codes for the run-length pattern decoder.
package lrpd_pkg;

  localparam int unsigned CoordBitsDefault = 32;
  localparam int unsigned CountBitsDefault = 24;
  localparam int unsigned CmdFifoDepth     = 4;

  localparam logic [7:0] ChEnd     = 8'h21;  // '!'
  localparam logic [7:0] ChNewline = 8'h0a;  // '\n'
  localparam logic [7:0] ChHash    = 8'h23;  // '#'
  localparam logic [7:0] ChHeader  = 8'h78;  // 'x'
  localparam logic [7:0] ChRowEnd  = 8'h24;  // '$'
  localparam logic [7:0] ChDead    = 8'h62;  // 'b'
  localparam logic [7:0] ChAlive   = 8'h6f;  // 'o'
  localparam logic [7:0] ChDigit0  = 8'h30;  // '0'
  localparam logic [7:0] ChDigit9  = 8'h39;  // '9'

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ROW,
    OP_COL,
    OP_RUN
  } op_e;

  typedef struct packed {
    logic clear;
    op_e  op;
  } cmd_ctl_t;

endpackage

>>> hw/rtl/lrpd_front.sv
// Front end: byte parser that tracks line state and run count and issues commands.
module lrpd_front #(
  parameter int unsigned COUNT_BITS = lrpd_pkg::CountBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            byte_in_i,
  input  logic                  chunk_start_i,
  output logic                  push_o,
  output lrpd_pkg::cmd_ctl_t    cmd_ctl_o,
  output logic [COUNT_BITS-1:0] cmd_count_o
);
  import lrpd_pkg::*;

  logic                  line_start_q, line_start_d;
  logic                  comment_q, comment_d;
  logic                  ended_q, ended_d;
  logic [COUNT_BITS-1:0] count_q, count_d;

  logic                  cur_line_start;
  logic                  cur_comment;
  logic                  cur_ended;
  logic [COUNT_BITS-1:0] cur_count;
  logic [COUNT_BITS+3:0] count_x10;
  logic                  is_digit;
  op_e                   op;

  assign cur_line_start = chunk_start_i ? 1'b1 : line_start_q;
  assign cur_comment    = chunk_start_i ? 1'b0 : comment_q;
  assign cur_ended      = chunk_start_i ? 1'b0 : ended_q;
  assign cur_count      = chunk_start_i ? '0 : count_q;

  assign is_digit  = (byte_in_i >= ChDigit0) && (byte_in_i <= ChDigit9);
  assign count_x10 = ({4'b0, cur_count} << 3) + ({4'b0, cur_count} << 1)
                   + {{COUNT_BITS{1'b0}}, byte_in_i[3:0]};

  always_comb begin
    line_start_d = cur_line_start;
    comment_d    = cur_comment;
    ended_d      = cur_ended;
    count_d      = cur_count;
    op           = OP_NONE;
    if (cur_ended || (byte_in_i == ChEnd)) begin
      ended_d = 1'b1;
    end else if (byte_in_i == ChNewline) begin
      line_start_d = 1'b1;
    end else begin
      line_start_d = 1'b0;
      if (cur_line_start) begin
        comment_d = (byte_in_i == ChHash) || (byte_in_i == ChHeader);
      end
      if (!comment_d) begin
        case (byte_in_i)
          ChRowEnd: begin
            op      = OP_ROW;
            count_d = '0;
          end
          ChDead: begin
            op      = OP_COL;
            count_d = '0;
          end
          ChAlive: begin
            op      = OP_RUN;
            count_d = '0;
          end
          default: begin
            if (is_digit) begin
              if (count_x10[COUNT_BITS+3:COUNT_BITS] != 4'd0) begin
                count_d = '1;
              end else begin
                count_d = count_x10[COUNT_BITS-1:0];
              end
            end
          end
        endcase
      end
    end
  end

  assign cmd_ctl_o.clear = chunk_start_i;
  assign cmd_ctl_o.op    = op;
  assign cmd_count_o     = (cur_count == '0) ? COUNT_BITS'(1) : cur_count;
  assign push_o          = accept_i && (chunk_start_i || (op != OP_NONE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_start_q <= 1'b1;
      comment_q    <= 1'b0;
      ended_q      <= 1'b0;
      count_q      <= '0;
    end else if (accept_i) begin
      line_start_q <= line_start_d;
      comment_q    <= comment_d;
      ended_q      <= ended_d;
      count_q      <= count_d;
    end
  end

endmodule

>>> hw/rtl/lrpd_fifo.sv
// Small command queue between the parser and the position unit.
module lrpd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = lrpd_pkg::CmdFifoDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             not_empty_o,
  output logic [WIDTH-1:0] head_data_o
);
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic             do_push, do_pop;

  assign full_o      = (fill_q == CntW'(DEPTH));
  assign not_empty_o = (fill_q != '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign head_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    fill_d = fill_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

>>> hw/rtl/lrpd_back.sv
// Back end: keeps the column and row position and registers emitted runs.
module lrpd_back #(
  parameter int unsigned COORD_BITS = lrpd_pkg::CoordBitsDefault,
  parameter int unsigned COUNT_BITS = lrpd_pkg::CountBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  lrpd_pkg::cmd_ctl_t    head_ctl_i,
  input  logic [COUNT_BITS-1:0] head_count_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] run_col_o,
  output logic [COORD_BITS-1:0] run_row_o,
  output logic [COUNT_BITS-1:0] run_len_o
);
  import lrpd_pkg::*;

  localparam int unsigned SumW = ((COORD_BITS > COUNT_BITS) ? COORD_BITS : COUNT_BITS) + 1;

  logic [COORD_BITS-1:0] col_q, col_d;
  logic [COORD_BITS-1:0] row_q, row_d;
  logic                  out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0] run_col_q;
  logic [COORD_BITS-1:0] run_row_q;
  logic [COUNT_BITS-1:0] run_len_q;

  logic [COORD_BITS-1:0] base_col, base_row;
  logic [SumW-1:0]       col_sum, row_sum;
  logic [COORD_BITS-1:0] col_sat, row_sat;
  logic                  is_run, load_out;

  assign base_col = head_ctl_i.clear ? '0 : col_q;
  assign base_row = head_ctl_i.clear ? '0 : row_q;

  assign col_sum = SumW'(base_col) + SumW'(head_count_i);
  assign row_sum = SumW'(base_row) + SumW'(head_count_i);
  assign col_sat = (col_sum[SumW-1:COORD_BITS] != '0) ? '1 : col_sum[COORD_BITS-1:0];
  assign row_sat = (row_sum[SumW-1:COORD_BITS] != '0) ? '1 : row_sum[COORD_BITS-1:0];

  assign is_run   = (head_ctl_i.op == OP_RUN);
  assign pop_o    = head_valid_i && (!is_run || !out_valid_q || !out_stall_i);
  assign load_out = pop_o && is_run;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (pop_o) begin
      col_d = base_col;
      row_d = base_row;
      unique case (head_ctl_i.op)
        OP_ROW: begin
          row_d = row_sat;
          col_d = '0;
        end
        OP_COL:  col_d = col_sat;
        OP_RUN:  col_d = col_sat;
        default: ;
      endcase
    end
  end

  assign out_valid_d = load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      run_col_q <= base_col;
      run_row_q <= base_row;
      run_len_q <= head_count_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign run_col_o   = run_col_q;
  assign run_row_o   = run_row_q;
  assign run_len_o   = run_len_q;

endmodule

>>> hw/rtl/life_rle_pattern_decoder.sv
// Top level of the run-length pattern decoder.
// Takes one pattern text byte per cycle and emits one run record (start column, row,
// length) for every alive-cell command; a byte with chunk_start_i set clears all parser
// and position state before it is decoded. Each byte is decoded in the cycle it is
// accepted, and its command is written into a four-entry command queue at that same edge.
// The position unit takes each command from the queue head and loads a run into the output
// register, so a run passes through the command queue and then the output register; a stalled
// run or earlier queued commands can hold it back. The input stalls only when the command queue
// is full, which happens only while the output side holds a run stalled and further commands
// pile up behind it.
module life_rle_pattern_decoder #(
  parameter int unsigned COORD_BITS = lrpd_pkg::CoordBitsDefault,
  parameter int unsigned COUNT_BITS = lrpd_pkg::CountBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            byte_in_i,
  input  logic                  chunk_start_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] run_col_o,
  output logic [COORD_BITS-1:0] run_row_o,
  output logic [COUNT_BITS-1:0] run_len_o
);
  import lrpd_pkg::*;

  localparam int unsigned CmdW = $bits(cmd_ctl_t) + COUNT_BITS;

  logic                  accept;
  logic                  push;
  cmd_ctl_t              push_ctl;
  logic [COUNT_BITS-1:0] push_count;
  logic                  fifo_full;
  logic                  head_valid;
  logic [CmdW-1:0]       head_data;
  cmd_ctl_t              head_ctl;
  logic [COUNT_BITS-1:0] head_count;
  logic                  pop;

  assign in_stall_o = fifo_full;
  assign accept     = in_valid_i && !fifo_full;

  lrpd_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .byte_in_i    (byte_in_i),
    .chunk_start_i(chunk_start_i),
    .push_o       (push),
    .cmd_ctl_o    (push_ctl),
    .cmd_count_o  (push_count)
  );

  lrpd_fifo #(
    .WIDTH(CmdW),
    .DEPTH(CmdFifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i({push_ctl, push_count}),
    .full_o     (fifo_full),
    .pop_i      (pop),
    .not_empty_o(head_valid),
    .head_data_o(head_data)
  );

  assign head_ctl   = cmd_ctl_t'(head_data[CmdW-1:COUNT_BITS]);
  assign head_count = head_data[COUNT_BITS-1:0];

  lrpd_back #(
    .COORD_BITS(COORD_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_ctl_i  (head_ctl),
    .head_count_i(head_count),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .run_col_o   (run_col_o),
    .run_row_o   (run_row_o),
    .run_len_o   (run_len_o)
  );

endmodule

>>> tb/sv/life_rle_pattern_decoder_tb.sv
// Self-checking testbench for the run-length pattern decoder.
`timescale 1ns / 100ps

module life_rle_pattern_decoder_tb;
  import lrpd_pkg::*;

  localparam int CoordW = CoordBitsDefault;
  localparam int CountW = CountBitsDefault;
  localparam int unsigned Items = 1000;
  localparam int unsigned StuckLimit = 2000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned HoldCycles = 300;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef struct packed {
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [CountW-1:0] len;
  } run_t;

  class run_tracker;
    logic [CoordW-1:0] col_pos;
    logic [CoordW-1:0] row_pos;
    logic [CountW-1:0] run_count;
    bit at_line_start;
    bit in_comment;
    bit ended;
    run_t pending_runs[$];
    int unsigned mismatches;

    function new();
      clear();
      mismatches = 0;
    endfunction

    function void clear();
      col_pos = '0;
      row_pos = '0;
      run_count = '0;
      at_line_start = 1'b1;
      in_comment = 1'b0;
      ended = 1'b0;
    endfunction

    function logic [CountW-1:0] take_count();
      logic [CountW-1:0] n;
      n = (run_count == '0) ? CountW'(1) : run_count;
      run_count = '0;
      return n;
    endfunction

    function logic [CoordW-1:0] advance(logic [CoordW-1:0] pos, logic [CountW-1:0] n);
      logic [CoordW:0] sum;
      sum = {1'b0, pos} + n;
      return sum[CoordW] ? {CoordW{1'b1}} : sum[CoordW-1:0];
    endfunction

    function void take_byte(logic [7:0] ch, logic clear_first);
      run_t run;
      logic [CountW-1:0] n;
      longint unsigned digit;
      if (clear_first) clear();
      if (ch == ChEnd) ended = 1'b1;
      if (ended) return;
      if (ch == ChNewline) begin
        at_line_start = 1'b1;
        return;
      end
      if (at_line_start) begin
        at_line_start = 1'b0;
        in_comment = (ch == ChHash) || (ch == ChHeader);
      end
      if (in_comment) return;
      case (ch)
        ChRowEnd: begin
          n = take_count();
          row_pos = advance(row_pos, n);
          col_pos = '0;
        end
        ChDead: begin
          n = take_count();
          col_pos = advance(col_pos, n);
        end
        ChAlive: begin
          n = take_count();
          run.col = col_pos;
          run.row = row_pos;
          run.len = n;
          pending_runs = {pending_runs, run};
          col_pos = advance(col_pos, n);
        end
        default: begin
          if (ch < ChDigit0 || ch > ChDigit9) return;
          digit = ch - ChDigit0;
          if (run_count > (CountMax - digit) / 10) run_count = CountMax;
          else run_count = CountW'(run_count * 10 + digit);
        end
      endcase
    endfunction

    task report_mismatch(string what);
      if (mismatches < 100) $display("ERROR at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_run(logic [CoordW-1:0] col, logic [CoordW-1:0] row, logic [CountW-1:0] len);
      run_t want;
      if (pending_runs.size() == 0) begin
        report_mismatch($sformatf("unexpected run col=%0d row=%0d len=%0d", col, row, len));
        return;
      end
      want = pending_runs.pop_front();
      if (col !== want.col)
        report_mismatch($sformatf("run_col %0d, expected %0d", col, want.col));
      if (row !== want.row)
        report_mismatch($sformatf("run_row %0d, expected %0d", row, want.row));
      if (len !== want.len)
        report_mismatch($sformatf("run_len %0d, expected %0d", len, want.len));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [7:0] byte_in;
  logic chunk_start;
  logic out_valid;
  logic out_stall;
  logic [CoordW-1:0] run_col;
  logic [CoordW-1:0] run_row;
  logic [CountW-1:0] run_len;

  run_tracker tracker;
  int unsigned sent;
  int unsigned runs_seen;
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  int unsigned pct_choices[3] = '{0, 15, 50};
  bit quiet;
  bit hold_done;
  bit clear_pending;

  life_rle_pattern_decoder dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .byte_in_i    (byte_in),
    .chunk_start_i(chunk_start),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .run_col_o    (run_col),
    .run_row_o    (run_row),
    .run_len_o    (run_len)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task send_byte(logic [7:0] ch);
    int unsigned gap;
    logic clear_first;
    clear_first = clear_pending;
    clear_pending = 1'b0;
    if (!quiet && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    byte_in <= ch;
    chunk_start <= clear_first;
    do @(posedge clk); while (in_stall);
    tracker.take_byte(ch, clear_first);
    sent++;
    @(negedge clk);
  endtask

  task send_count(longint unsigned n);
    string digits;
    digits = $sformatf("%0d", n);
    for (int i = 0; i < digits.len(); i++) send_byte(digits[i]);
  endtask

  task random_token();
    int unsigned pick;
    int unsigned k;
    int unsigned len;
    if (tracker.ended && $urandom_range(0, 3) != 0) clear_pending = 1'b1;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      k = $urandom_range(0, 99);
      if (k >= 93) send_count({$urandom, $urandom} % 64'd10_000_000_000);
      else if (k >= 75) send_count($urandom_range(0, 100000));
      else if (k >= 35) send_count($urandom_range(0, 30));
      if ($urandom_range(0, 19) == 0) send_byte(ChNewline);
      k = $urandom_range(0, 9);
      send_byte(k < 5 ? ChAlive : (k < 8 ? ChDead : ChRowEnd));
    end else if (pick < 78) begin
      send_byte(ChNewline);
      send_byte($urandom_range(0, 1) ? ChHash : ChHeader);
      len = $urandom_range(0, 8);
      repeat (len) send_byte(8'($urandom_range(32, 126)));
      send_byte(ChNewline);
    end else if (pick < 86) begin
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 90) begin
      send_byte(ChEnd);
      len = $urandom_range(0, 3);
      repeat (len) send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 94) begin
      clear_pending = 1'b1;
    end else begin
      send_byte(ChNewline);
    end
  endtask

  initial begin
    tracker = new();
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    byte_in = '0;
    chunk_start = 1'b0;
    out_stall = 1'b0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    quiet = 1'b0;
    hold_done = 1'b0;
    clear_pending = 1'b0;
    sent = 0;
    runs_seen = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    clear_pending = 1'b1;
    send_byte(ChAlive);
    send_count(0);
    send_byte(ChAlive);
    send_count(3);
    send_byte(ChDead);
    send_count(2);
    send_byte(ChAlive);
    send_byte(8'hff);
    send_byte(8'h00);
    send_count(2);
    send_byte(ChNewline);
    send_byte(ChRowEnd);
    send_count(99999999);
    send_byte(ChAlive);
    send_byte(ChNewline);
    send_byte(ChHash);
    send_byte(ChEnd);
    send_byte(ChAlive);
    clear_pending = 1'b1;
    send_byte(ChHeader);
    send_byte(ChNewline);
    send_byte(ChAlive);

    in_idle_pct = 15;
    out_stall_pct = 15;
    while (sent < Items * 85 / 100) begin
      if ($urandom_range(0, 63) == 0) begin
        in_idle_pct = pct_choices[$urandom_range(0, 2)];
        out_stall_pct = pct_choices[$urandom_range(0, 2)];
      end
      random_token();
    end

    quiet = 1'b1;
    while (sent < Items) random_token();
    in_valid <= 1'b0;

    while (tracker.pending_runs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && !quiet && runs_seen >= 20) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < out_stall_pct) begin
        out_stall <= 1'b1;
        gap = $urandom_range(1, 10);
        repeat (gap) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      runs_seen++;
      tracker.check_run(run_col, run_row, run_len);
    end
  end

  initial begin
    int unsigned stuck_cycles;
    stuck_cycles = 0;
    while (stuck_cycles < StuckLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
      else stuck_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

endmodule
